### design/rfd_pkg.sv
`default_nettype none
package rfd_pkg;

  localparam int HIST_DEPTH   = 32768;
  localparam int MAX_CHANNELS = 8;

  localparam int SAMPLE_W = 24;
  localparam int CH_W     = $clog2(MAX_CHANNELS);
  localparam int POS_W    = $clog2(HIST_DEPTH);
  localparam int FILL_W   = POS_W + 1;
  localparam int ADDR_W   = CH_W + POS_W;
  localparam int DELAY_W  = 31;
  localparam int STEP_W   = 32;
  localparam int RAMP_W   = 11;
  localparam int ACH_W    = 4;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;

  // Largest delay in Q15.16
  localparam logic [STEP_W:0] DELAY_LIMIT = (STEP_W+1)'(HIST_DEPTH) << FRAC_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANS  = 2'd2;

  // Request to the step divider
  typedef struct packed {
    logic                     start;
    logic signed [STEP_W:0]   dividend;
    logic [RAMP_W-1:0]        divisor;
  } div_req_t;

endpackage
`default_nettype wire

### design/ramped_fractional_delay_line_top.sv
`default_nettype none
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall   in_sample, in_channel
// out      output     out_valid/out_stall out_sample, out_channel
// cfg      input      cfg_we              cfg_index, cfg_wdata
//
// A request runs through RDA, RDB, MUL, WR and FIN after acceptance, with ADV
// first at a frame head where the ramp advances; zero delay skips RDB and MUL,
// a channel outside the count goes straight to FIN, and a retarget waits in DIV for the divider.
// Reset (rst_n low, synchronous) clears control state; no clearing pass:
// per-channel fill counts make unwritten history read as zero.
// A result waiting under out_stall holds the next item at its last cycle.
module ramped_fractional_delay_line_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire signed [rfd_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire [rfd_pkg::CH_W-1:0]              in_channel,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [rfd_pkg::SAMPLE_W-1:0]  out_sample,
  output logic [rfd_pkg::CH_W-1:0]             out_channel,
  input  wire                                  cfg_we,
  input  wire [rfd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [rfd_pkg::CFG_W-1:0]             cfg_wdata
);
  import rfd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ADV  = 3'd2;
  localparam logic [2:0] ST_RDA  = 3'd3;
  localparam logic [2:0] ST_RDB  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_WR   = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  localparam int PROD_W = SAMPLE_W + 1 + FRAC_W + 1;

  logic [2:0]                 state_r;
  logic signed [SAMPLE_W-1:0] x_r, y_r, a_r, out_sample_r;
  logic [CH_W-1:0]            ch_r, out_channel_r;
  logic                       out_valid_r;
  logic                       live_r;
  logic                       sum_r;
  logic [DELAY_W-1:0]         cur_r, lat_r, tgt_r;
  logic signed [STEP_W-1:0]   step_r;
  logic [RAMP_W-1:0]          ramp_r, rf_r;
  logic                       taken_r;
  logic [ACH_W-1:0]           ach_r, seen_r;
  logic [POS_W-1:0]           wpos_r [MAX_CHANNELS];
  logic [FILL_W-1:0]          fill_r [MAX_CHANNELS];
  logic signed [PROD_W-1:0]   prod_r;

  logic [SAMPLE_W-1:0]        mem [MAX_CHANNELS * HIST_DEPTH];
  logic [SAMPLE_W-1:0]        rd_q;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       mem_we;

  div_req_t                   div_req;
  logic                       div_done;
  logic signed [STEP_W-1:0]   div_quot;

  logic                       in_acc;
  logic                       ch_ok;
  logic [STEP_W:0]            tgt_clamp;
  logic [DELAY_W-1:0]         target;
  logic [RAMP_W-1:0]          rf_eff;
  logic [POS_W-1:0]           lower;
  logic [FRAC_W-1:0]          frac;
  logic [POS_W-1:0]           pos_a;
  logic                       a_ok, b_ok;
  logic signed [SAMPLE_W-1:0] b_val;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   a_ext;
  logic signed [PROD_W-1:0]   sum;
  logic [STEP_W:0]            adv_sum;

  assign in_stall = state_r != ST_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign ch_ok    = ach_r != '0 && ach_r <= ACH_W'(MAX_CHANNELS)
                    && {1'b0, in_channel} < ach_r;

  // Clamp the target and guard a zero ramp length
  assign tgt_clamp = {2'b0, tgt_r} > DELAY_LIMIT ? DELAY_LIMIT : {2'b0, tgt_r};
  assign target    = tgt_clamp[DELAY_W-1:0];
  assign rf_eff    = rf_r == '0 ? RAMP_W'(1) : rf_r;

  // Split the delay and find the history slots
  assign lower = cur_r[DELAY_W-1:FRAC_W];
  assign frac  = cur_r[FRAC_W-1:0];
  assign pos_a = wpos_r[ch_r] - lower;
  assign a_ok  = fill_r[ch_r] >= {1'b0, lower};
  assign b_ok  = fill_r[ch_r] >= {1'b0, lower} + FILL_W'(1);

  always_comb begin
    case (state_r)
      ST_RDB:  rd_addr = {ch_r, pos_a - POS_W'(1)};
      default: rd_addr = {ch_r, pos_a};
    endcase
  end

  assign mem_we = state_r == ST_WR && live_r;

  // History memory: one write port and one read port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{ch_r, wpos_r[ch_r]}] <= x_r;
    end
    rd_q <= mem[rd_addr];
  end

  // Step divider request
  assign div_req.start    = in_acc && ch_ok && seen_r == '0 && taken_r
                            && target != lat_r;
  assign div_req.dividend = $signed({2'b0, target}) - $signed({2'b0, cur_r});
  assign div_req.divisor  = rf_eff;

  rfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Interpolation arithmetic
  assign b_val   = b_ok ? $signed(rd_q) : '0;
  assign diff    = $signed({b_val[SAMPLE_W-1], b_val}) - $signed({a_r[SAMPLE_W-1], a_r});
  assign a_ext   = PROD_W'(a_r);
  assign sum     = a_ext + (prod_r >>> FRAC_W);
  assign adv_sum = $signed({2'b0, cur_r}) + $signed({step_r[STEP_W-1], step_r});

  // Sequencer and state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      cur_r       <= '0;
      lat_r       <= '0;
      step_r      <= '0;
      ramp_r      <= '0;
      taken_r     <= 1'b0;
      seen_r      <= '0;
      tgt_r       <= '0;
      rf_r        <= RAMP_W'(240);
      ach_r       <= ACH_W'(1);
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        wpos_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET: tgt_r <= cfg_wdata[DELAY_W-1:0];
          REG_RAMP:   rf_r  <= cfg_wdata[RAMP_W-1:0];
          REG_CHANS: begin
            if (cfg_wdata[ACH_W-1:0] != ach_r) begin
              ach_r  <= cfg_wdata[ACH_W-1:0];
              seen_r <= '0;
              for (int i = 0; i < MAX_CHANNELS; i++) begin
                wpos_r[i] <= '0;
                fill_r[i] <= '0;
              end
            end
          end
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            x_r    <= in_sample;
            ch_r   <= in_channel;
            y_r    <= in_sample;
            live_r <= ch_ok;
            if (!ch_ok) begin
              state_r <= ST_FIN;
            end else if (seen_r != '0) begin
              state_r <= ST_RDA;
            end else if (!taken_r) begin
              cur_r   <= target;
              lat_r   <= target;
              taken_r <= 1'b1;
              state_r <= ST_ADV;
            end else if (target != lat_r) begin
              lat_r   <= target;
              ramp_r  <= rf_eff;
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_ADV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            step_r  <= div_quot;
            state_r <= ST_ADV;
          end
        end
        ST_ADV: begin
          if (ramp_r != '0) begin
            ramp_r <= ramp_r - 1'b1;
            cur_r  <= ramp_r == RAMP_W'(1) ? lat_r : adv_sum[DELAY_W-1:0];
          end
          state_r <= ST_RDA;
        end
        ST_RDA: begin
          // Zero delay passes the sample through
          state_r <= cur_r == '0 ? ST_WR : ST_RDB;
        end
        ST_RDB: begin
          if (lower == '0) begin
            a_r <= x_r;
          end else begin
            a_r <= a_ok ? $signed(rd_q) : '0;
          end
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= diff * $signed({1'b0, frac});
          sum_r   <= 1'b1;
          state_r <= ST_WR;
        end
        ST_WR: begin
          if (sum_r) begin
            y_r <= (frac == '0 || {1'b0, lower} >= FILL_W'(HIST_DEPTH)) ? a_r
                   : sum[SAMPLE_W-1:0];
          end
          sum_r <= 1'b0;
          // Advance the ring and the frame position
          wpos_r[ch_r] <= wpos_r[ch_r] + 1'b1;
          if (fill_r[ch_r] != FILL_W'(HIST_DEPTH)) begin
            fill_r[ch_r] <= fill_r[ch_r] + 1'b1;
          end
          seen_r  <= ({1'b0, ch_r} == ach_r - 1'b1) ? '0 : seen_r + 1'b1;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // Hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_sample_r  <= y_r;
            out_channel_r <= ch_r;
            out_valid_r   <= 1'b1;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_channel = out_channel_r;

`ifndef ASSERT_OFF
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final state");

  a_ramp_needs_target: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_r != '0 |-> taken_r)
    else $error("ramp running before a target was taken");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[ch_r] <= FILL_W'(HIST_DEPTH))
    else $error("fill count beyond ring depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("request accepted without leaving idle");
`endif

endmodule
`default_nettype wire

### design/rfd_div.sv
`default_nettype none
module rfd_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  rfd_pkg::div_req_t            req,
  output logic                         done,
  output logic signed [rfd_pkg::STEP_W-1:0] quot
);
  import rfd_pkg::*;

  localparam int CNT_W = $clog2(STEP_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [RAMP_W-1:0]    rem_r;
  logic [STEP_W-1:0]    q_r;
  logic [RAMP_W-1:0]    dsr_r;
  logic                 neg_r;
  logic [RAMP_W:0]      trial;
  logic                 qbit;
  logic [STEP_W:0]      mag;

  // Magnitude of the dividend, sign kept aside
  assign mag = req.dividend[STEP_W] ? (STEP_W+1)'(0) - req.dividend : req.dividend;

  // One restoring step: shift in the next dividend bit and try the divisor
  assign trial = {rem_r, q_r[STEP_W-1]};
  assign qbit  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEP_W);
        rem_r  <= '0;
        q_r    <= mag[STEP_W-1:0];
        dsr_r  <= req.divisor;
        neg_r  <= req.dividend[STEP_W];
      end else if (busy_r) begin
        rem_r <= qbit ? RAMP_W'(trial - {1'b0, dsr_r}) : trial[RAMP_W-1:0];
        q_r   <= {q_r[STEP_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restore the sign: truncation toward zero
  assign done = done_r;
  assign quot = neg_r ? $signed(STEP_W'(0) - q_r) : $signed(q_r);

endmodule
`default_nettype wire
